// ===== sv/sfr_pkg.sv =====
// Shared constants, phase codes and result type for the serial frame receiver.
package sfr_pkg;

    localparam int MAX_FRAME_DEF  = 256;
    localparam int FRAME_OVERHEAD = 8;
    localparam int SUM_W          = 16;

    localparam logic [7:0] HDR1_BYTE  = 8'hFA;
    localparam logic [7:0] END_BYTE   = 8'hFC;
    localparam logic [7:0] ID_CLIENT  = 8'h5B;
    localparam logic [7:0] ID_SERVER  = 8'h5A;

    localparam logic [3:0] PH_HEAD1 = 4'd0;
    localparam logic [3:0] PH_HEAD2 = 4'd1;
    localparam logic [3:0] PH_LEN1  = 4'd2;
    localparam logic [3:0] PH_LEN2  = 4'd3;
    localparam logic [3:0] PH_CMD   = 4'd4;
    localparam logic [3:0] PH_DATA  = 4'd5;
    localparam logic [3:0] PH_CS1   = 4'd6;
    localparam logic [3:0] PH_CS2   = 4'd7;
    localparam logic [3:0] PH_END   = 4'd8;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_CSUM    = 2'd2;
    localparam logic [1:0] KIND_BAD_END = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_cmd;
        logic [7:0] frame_len;
    } result_t;

endpackage

// ===== sv/serial_frame_receiver.sv =====
// Serial frame receiver: byte-stream deframer with a 16-bit additive checksum.
// One received byte is taken per cycle while the output side keeps up; each byte
// passes an input register, the frame-state logic and a result register, so a
// result is registered before it is presented. Payload bytes come out as they
// arrive, and the end-byte position gives one status item (good, checksum error
// or bad end byte). Only bytes that produce a result can be held back by a
// stalled output. The expected second header byte is written through
// rx_header_id_we and resets to 0x5B. Lengths above MAX_FRAME - 8 drop the
// frame silently.
module serial_frame_receiver #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_header_id_we,
    input  logic [7:0] rx_header_id,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] frame_cmd,
    output logic [7:0] frame_len
);

    logic             byte_valid;
    logic             byte_stall;
    logic [7:0]       byte_data;
    logic             res_valid;
    logic             res_stall;
    sfr_pkg::result_t res;
    sfr_pkg::result_t res_out;

    sfr_stage_reg #(
        .W (8)
    ) u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .up_data  (rx_byte),
        .dn_valid (byte_valid),
        .dn_stall (byte_stall),
        .dn_data  (byte_data)
    );

    sfr_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .id_we      (rx_header_id_we),
        .id_data    (rx_header_id),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    sfr_stage_reg #(
        .W ($bits(sfr_pkg::result_t))
    ) u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (res_valid),
        .up_stall (res_stall),
        .up_data  (res),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .dn_data  (res_out)
    );

    assign kind          = res_out.kind;
    assign payload_byte  = res_out.payload_byte;
    assign payload_index = res_out.payload_index;
    assign frame_cmd     = res_out.frame_cmd;
    assign frame_len     = res_out.frame_len;

endmodule

// ===== sv/sfr_stage_reg.sv =====
// Valid/stall pipeline register holding one item.
module sfr_stage_reg #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_stall,
    input  logic [W-1:0] up_data,
    output logic         dn_valid,
    input  logic         dn_stall,
    output logic [W-1:0] dn_data
);

    logic         valid_reg;
    logic         valid_next;
    logic [W-1:0] data_reg;
    logic         load;

    // a held item blocks the upstream only while the downstream stalls it
    assign up_stall   = valid_reg && dn_stall;
    assign load       = up_valid && !up_stall;
    assign valid_next = load || (valid_reg && dn_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= up_data;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== sv/sfr_parser.sv =====
// Frame state machine: one byte per cycle unless a stalled result holds it, at most one result per byte.
module sfr_parser #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   id_we,
    input  logic [7:0]             id_data,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  logic [7:0]             byte_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output sfr_pkg::result_t       res
);

    localparam int LEN_MAX = MAX_FRAME - sfr_pkg::FRAME_OVERHEAD;
    localparam int LEN_W   = $clog2(LEN_MAX + 1);

    logic [7:0]                 header_id_reg;
    logic [3:0]                 phase_reg, phase_next;
    logic [7:0]                 length_low_reg, length_low_next;
    logic [LEN_W-1:0]           payload_length_reg, payload_length_next;
    logic [7:0]                 command_reg, command_next;
    logic [LEN_W-1:0]           byte_count_reg, byte_count_next;
    logic [sfr_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [7:0]                 cs_low_reg, cs_low_next;
    logic [sfr_pkg::SUM_W-1:0]  cs_rx_reg, cs_rx_next;

    logic                       produces;
    logic                       step;
    logic [15:0]                len_word;
    logic [15:0]                count_wide;
    logic [15:0]                length_wide;
    logic [LEN_W-1:0]           count_inc;
    logic [sfr_pkg::SUM_W-1:0]  sum_add;

    assign len_word    = {byte_data, length_low_reg};
    assign count_wide  = 16'(byte_count_reg);
    assign length_wide = 16'(payload_length_reg);
    assign count_inc   = byte_count_reg + LEN_W'(1);
    assign sum_add     = sum_reg + sfr_pkg::SUM_W'(byte_data);

    assign produces   = (phase_reg == sfr_pkg::PH_DATA) || (phase_reg == sfr_pkg::PH_END);
    assign byte_stall = produces && res_stall;
    assign step       = byte_valid && !byte_stall;
    assign res_valid  = byte_valid && produces;

    always_comb
    begin
        res.kind          = sfr_pkg::KIND_PAYLOAD;
        res.payload_byte  = 8'd0;
        res.payload_index = 8'd0;
        res.frame_cmd     = command_reg;
        res.frame_len     = length_wide[7:0];
        if (phase_reg == sfr_pkg::PH_DATA)
        begin
            res.payload_byte  = byte_data;
            res.payload_index = count_wide[7:0];
        end
        else if (byte_data != sfr_pkg::END_BYTE)
        begin
            res.kind = sfr_pkg::KIND_BAD_END;
        end
        else if (cs_rx_reg == sum_reg)
        begin
            res.kind = sfr_pkg::KIND_GOOD;
        end
        else
        begin
            res.kind = sfr_pkg::KIND_CSUM;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        length_low_next     = length_low_reg;
        payload_length_next = payload_length_reg;
        command_next        = command_reg;
        byte_count_next     = byte_count_reg;
        sum_next            = sum_reg;
        cs_low_next         = cs_low_reg;
        cs_rx_next          = cs_rx_reg;
        case (phase_reg)
            sfr_pkg::PH_HEAD1:
            begin
                if (byte_data == sfr_pkg::HDR1_BYTE)
                begin
                    phase_next = sfr_pkg::PH_HEAD2;
                    sum_next   = sfr_pkg::SUM_W'(sfr_pkg::HDR1_BYTE);
                end
            end
            sfr_pkg::PH_HEAD2:
            begin
                if (byte_data == header_id_reg)
                begin
                    sum_next   = sum_add;
                    phase_next = sfr_pkg::PH_LEN1;
                end
                else if (byte_data != sfr_pkg::HDR1_BYTE)
                begin
                    phase_next = sfr_pkg::PH_HEAD1;
                end
            end
            sfr_pkg::PH_LEN1:
            begin
                length_low_next = byte_data;
                sum_next        = sum_add;
                phase_next      = sfr_pkg::PH_LEN2;
            end
            sfr_pkg::PH_LEN2:
            begin
                sum_next = sum_add;
                // oversized frames are dropped without a report
                if (len_word > 16'(LEN_MAX))
                begin
                    phase_next = sfr_pkg::PH_HEAD1;
                end
                else
                begin
                    payload_length_next = len_word[LEN_W-1:0];
                    phase_next          = sfr_pkg::PH_CMD;
                end
            end
            sfr_pkg::PH_CMD:
            begin
                command_next    = byte_data;
                sum_next        = sum_add;
                byte_count_next = '0;
                phase_next      = (payload_length_reg != '0) ? sfr_pkg::PH_DATA
                                                             : sfr_pkg::PH_CS1;
            end
            sfr_pkg::PH_DATA:
            begin
                sum_next        = sum_add;
                byte_count_next = count_inc;
                if (count_inc >= payload_length_reg)
                begin
                    phase_next = sfr_pkg::PH_CS1;
                end
            end
            sfr_pkg::PH_CS1:
            begin
                cs_low_next = byte_data;
                phase_next  = sfr_pkg::PH_CS2;
            end
            sfr_pkg::PH_CS2:
            begin
                cs_rx_next = {byte_data, cs_low_reg};
                phase_next = sfr_pkg::PH_END;
            end
            sfr_pkg::PH_END:
            begin
                // a stray header byte here starts the next frame
                if (byte_data != sfr_pkg::END_BYTE && byte_data == sfr_pkg::HDR1_BYTE)
                begin
                    phase_next = sfr_pkg::PH_HEAD2;
                    sum_next   = sfr_pkg::SUM_W'(sfr_pkg::HDR1_BYTE);
                end
                else
                begin
                    phase_next = sfr_pkg::PH_HEAD1;
                end
            end
            default:
            begin
                phase_next = sfr_pkg::PH_HEAD1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_id_reg      <= sfr_pkg::ID_CLIENT;
            phase_reg          <= sfr_pkg::PH_HEAD1;
            length_low_reg     <= '0;
            payload_length_reg <= '0;
            command_reg        <= '0;
            byte_count_reg     <= '0;
            sum_reg            <= '0;
            cs_low_reg         <= '0;
            cs_rx_reg          <= '0;
        end
        else
        begin
            if (id_we)
            begin
                header_id_reg <= id_data;
            end
            if (step)
            begin
                phase_reg          <= phase_next;
                length_low_reg     <= length_low_next;
                payload_length_reg <= payload_length_next;
                command_reg        <= command_next;
                byte_count_reg     <= byte_count_next;
                sum_reg            <= sum_next;
                cs_low_reg         <= cs_low_next;
                cs_rx_reg          <= cs_rx_next;
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for serial_frame_receiver: random byte streams checked against a deframing predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int MAX_LEN = MAX_FRAME_DEF - FRAME_OVERHEAD;

    typedef struct {
        logic [7:0] data;
        int         gap;
    } rx_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_header_id_we = 1'b0;
    logic [7:0] rx_header_id = ID_CLIENT;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;

    rx_item_t byte_fifo[$];
    result_t  pending_results[$];
    int       in_wait = 0;
    int       out_wait = 0;
    int       out_draw;
    int       in_mode = 0;
    int       out_mode = 0;
    int       err_cnt = 0;
    int       bytes_queued = 0;

    // predictor state, reset values
    logic [7:0]  cur_id = ID_CLIENT;
    logic [3:0]  fr_phase = PH_HEAD1;
    logic [7:0]  len_low = 8'h00;
    logic [15:0] pay_len = 16'h0000;
    logic [7:0]  cmd_byte = 8'h00;
    logic [15:0] pay_count = 16'h0000;
    logic [15:0] run_sum = 16'h0000;
    logic [7:0]  cs_low = 8'h00;
    logic [15:0] cs_rcvd = 16'h0000;

    serial_frame_receiver i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_header_id_we (rx_header_id_we),
        .rx_header_id    (rx_header_id),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .payload_index   (payload_index),
        .frame_cmd       (frame_cmd),
        .frame_len       (frame_len)
    );

    always #10 clk = ~clk;

    // 0: never idle, 1: a random idle gap, possibly none, on every item, 2: idle now and then
    function automatic int draw_gap(input int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 19);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endfunction

    function automatic void push_result(input logic [1:0] k, input logic [7:0] pb,
                                        input logic [7:0] pi);
        result_t r;
        r.kind          = k;
        r.payload_byte  = pb;
        r.payload_index = pi;
        r.frame_cmd     = cmd_byte;
        r.frame_len     = pay_len[7:0];
        pending_results.push_back(r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] c);
        logic [15:0] full_len;
        case (fr_phase)
            PH_HEAD1:
            begin
                if (c == HDR1_BYTE)
                begin
                    fr_phase = PH_HEAD2;
                    run_sum  = 16'(HDR1_BYTE);
                end
            end
            PH_HEAD2:
            begin
                // the configured id wins over a repeated 0xFA
                if (c == cur_id)
                begin
                    run_sum  = run_sum + c;
                    fr_phase = PH_LEN1;
                end
                else if (c != HDR1_BYTE)
                    fr_phase = PH_HEAD1;
            end
            PH_LEN1:
            begin
                len_low  = c;
                run_sum  = run_sum + c;
                fr_phase = PH_LEN2;
            end
            PH_LEN2:
            begin
                full_len = {c, len_low};
                run_sum  = run_sum + c;
                if (full_len > MAX_LEN)
                    fr_phase = PH_HEAD1;
                else
                begin
                    pay_len  = full_len;
                    fr_phase = PH_CMD;
                end
            end
            PH_CMD:
            begin
                cmd_byte  = c;
                run_sum   = run_sum + c;
                pay_count = 16'h0000;
                fr_phase  = (pay_len > 0) ? PH_DATA : PH_CS1;
            end
            PH_DATA:
            begin
                run_sum = run_sum + c;
                push_result(KIND_PAYLOAD, c, pay_count[7:0]);
                pay_count = pay_count + 16'd1;
                if (pay_count >= pay_len)
                    fr_phase = PH_CS1;
            end
            PH_CS1:
            begin
                cs_low   = c;
                fr_phase = PH_CS2;
            end
            PH_CS2:
            begin
                cs_rcvd  = {c, cs_low};
                fr_phase = PH_END;
            end
            PH_END:
            begin
                if (c == END_BYTE)
                begin
                    push_result((cs_rcvd == run_sum) ? KIND_GOOD : KIND_CSUM, 8'h00, 8'h00);
                    fr_phase = PH_HEAD1;
                end
                else
                begin
                    push_result(KIND_BAD_END, 8'h00, 8'h00);
                    if (c == HDR1_BYTE)
                    begin
                        fr_phase = PH_HEAD2;
                        run_sum  = 16'(HDR1_BYTE);
                    end
                    else
                        fr_phase = PH_HEAD1;
                end
            end
            default:
                fr_phase = PH_HEAD1;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        if (err_cnt < 100)
            $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
        err_cnt++;
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result, kind", 8'h00, {6'd0, kind});
            return;
        end
        want = pending_results.pop_front();
        if (kind !== want.kind)
            report_mismatch("kind", {6'd0, want.kind}, {6'd0, kind});
        if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", want.payload_byte, payload_byte);
        if (payload_index !== want.payload_index)
            report_mismatch("payload_index", want.payload_index, payload_index);
        if (frame_cmd !== want.frame_cmd)
            report_mismatch("frame_cmd", want.frame_cmd, frame_cmd);
        if (frame_len !== want.frame_len)
            report_mismatch("frame_len", want.frame_len, frame_len);
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
            in_wait  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (in_wait > 0)
                begin
                    in_wait  <= in_wait - 1;
                    in_valid <= (in_wait == 1);
                end
                else if (byte_fifo.size() > 0)
                begin
                    rx_byte  <= byte_fifo[0].data;
                    in_wait  <= byte_fifo[0].gap;
                    in_valid <= (byte_fifo[0].gap == 0);
                    void'(byte_fifo.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait  <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            check_result();
            out_draw = draw_gap(out_mode);
            out_wait  <= out_draw;
            out_stall <= (out_draw != 0);
        end
        else if (out_wait > 0)
        begin
            out_wait  <= out_wait - 1;
            out_stall <= (out_wait > 1);
        end
    end

    task automatic push_byte(input logic [7:0] c);
        rx_item_t it;
        it.data = c;
        it.gap  = draw_gap(in_mode);
        byte_fifo.push_back(it);
        bytes_queued++;
    endtask

    // full frame; an oversized length stops after the length bytes
    task automatic push_frame(input logic [7:0] id, input logic [15:0] len,
                              input logic [7:0] cmd, input bit bad_cs,
                              input logic [7:0] tail);
        logic [15:0] s;
        logic [7:0]  p;
        s = 16'(HDR1_BYTE);
        s = s + id;
        s = s + len[7:0];
        s = s + len[15:8];
        push_byte(HDR1_BYTE);
        push_byte(id);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        if (len > MAX_LEN)
            return;
        s = s + cmd;
        push_byte(cmd);
        for (int i = 0; i < len; i++)
        begin
            p = 8'($urandom);
            s = s + p;
            push_byte(p);
        end
        if (bad_cs)
            s = s ^ 16'($urandom_range(1, 65535));
        push_byte(s[7:0]);
        push_byte(s[15:8]);
        push_byte(tail);
    endtask

    task automatic push_random_unit();
        int          r;
        int          f;
        logic [15:0] len;
        logic [7:0]  b;
        logic [7:0]  tail;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            len = ($urandom_range(0, 99) < 3) ? 16'($urandom_range(9, MAX_LEN))
                                              : 16'($urandom_range(0, 8));
            f = $urandom_range(0, 9);
            tail = END_BYTE;
            if (f >= 8)
            begin
                if ($urandom_range(0, 1) == 1)
                    tail = HDR1_BYTE;
                else
                begin
                    do tail = 8'($urandom); while (tail == END_BYTE);
                end
            end
            push_frame(cur_id, len, 8'($urandom), (f == 6 || f == 7), tail);
        end
        else if (r < 73)
        begin
            do b = 8'($urandom); while (b == HDR1_BYTE);
            push_byte(b);
        end
        else if (r < 80)
        begin
            do b = 8'($urandom); while (b == HDR1_BYTE || b == cur_id);
            if ($urandom_range(0, 1) == 1)
                push_byte(HDR1_BYTE);
            push_byte(HDR1_BYTE);
            push_byte(b);
        end
        else if (r < 88)
            push_frame(cur_id, 16'($urandom_range(MAX_LEN + 1, 65535)), 8'h00, 1'b0, END_BYTE);
        else
        begin
            // truncated frame: whatever follows lands mid-frame
            push_byte(HDR1_BYTE);
            push_byte(cur_id);
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (byte_fifo.size() != 0 || in_valid || in_wait != 0
               || pending_results.size() != 0)
            @(negedge clk);
        // a byte with no result may still be in the pipeline
        repeat (5) @(negedge clk);
    endtask

    task automatic write_header_id(input logic [7:0] v);
        @(posedge clk);
        rx_header_id_we <= 1'b1;
        rx_header_id    <= v;
        @(posedge clk);
        rx_header_id_we <= 1'b0;
        cur_id = v;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] id_list[6];
        int         k;
        id_list = '{8'h00, 8'hFF, ID_SERVER, HDR1_BYTE, END_BYTE, ID_CLIENT};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: noise, repeated 0xFA with empty frame, wrong id,
        // bad checksum, bad end byte that restarts a frame into an oversized length
        push_byte(8'hFF);
        push_byte(HDR1_BYTE);
        push_frame(ID_CLIENT, 16'd0, 8'hFF, 1'b0, END_BYTE);
        push_byte(HDR1_BYTE);
        push_byte(8'h00);
        push_frame(ID_CLIENT, 16'd1, 8'h00, 1'b1, END_BYTE);
        push_frame(ID_CLIENT, 16'd2, 8'h80, 1'b0, HDR1_BYTE);
        push_byte(ID_CLIENT);
        push_byte(8'hF9);
        push_byte(8'h00);
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            write_header_id(id_list[p]);
            in_mode  = (p == 1) ? 0 : $urandom_range(0, 2);
            out_mode = (p == 1) ? 0 : $urandom_range(0, 2);
            bytes_queued = 0;
            if (p == 2)
                push_frame(cur_id, 16'(MAX_LEN), 8'($urandom), 1'b0, END_BYTE);
            while (bytes_queued < 32)
                push_random_unit();
            if (p == 5)
            begin
                wait_idle();
                write_header_id(8'($urandom));
                while (bytes_queued < 60)
                    push_random_unit();
            end
            wait_idle();
        end

        k = 0;
        while (pending_results.size() != 0 && k < 2000)
        begin
            @(negedge clk);
            k++;
        end
        repeat (10) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never came, count", 8'h00, 8'(pending_results.size()));
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sfr_pkg.sv
sv/sfr_stage_reg.sv
sv/sfr_parser.sv
sv/serial_frame_receiver.sv
tb/sv/testbench.sv
